// ----- src/amef_pkg.sv -----
// Shared types, constants and register indexes for the angle median/EMA filter.
package amef_pkg;

  localparam int WINDOW_DEFAULT = 5;

  localparam int ANGLE_W  = 16;
  localparam int RAW_W    = 18;
  localparam int GAIN_W   = 16;
  localparam int RUN_W    = 8;
  localparam int CFG_AW   = 8;
  localparam int CFG_DW   = 16;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;

  localparam logic [GAIN_W-1:0]  EMA_GAIN_RST     = 16'd19661;
  localparam logic [ANGLE_W-1:0] ZERO_LIMIT_RST   = 16'd128;
  localparam logic [RUN_W-1:0]   ZERO_CONFIRM_RST = 8'd3;

  localparam logic [CFG_AW-1:0] REG_EMA_GAIN     = 8'd0;
  localparam logic [CFG_AW-1:0] REG_ZERO_LIMIT   = 8'd1;
  localparam logic [CFG_AW-1:0] REG_ZERO_CONFIRM = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MED_GO,
    ST_MED_WAIT,
    ST_EMA_GO,
    ST_EMA_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] median;
  } med_stat_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] value;
  } ema_stat_t;

endpackage

// ----- src/angle_median_ema_filter_core.sv -----
// Top level of the angle median/EMA filter: control sequencer, window pointers and ports.
//
// Input stream: one raw angle per transaction on in_*. It is clamped to 0..180 degrees.
// An angle at or below zero_limit is held back until zero_confirm_frames such angles
// arrive in a row. Accepted angles go into a WINDOW-entry RAM; the median of the filled
// entries feeds an exponential average. Every input transaction gives one result
// transaction on out_*: tdata carries the average, tuser the accepted and valid flags.
// A held-back angle goes from evaluation straight to the result; an accepted one first
// passes the rank scan that compares every pair of filled window entries through the two
// RAM read ports, then the average update, which is skipped when the first median loads
// the average directly. One item is in work at a time; in_tready is high while the
// sequencer is idle, so a new input is taken only once the previous result has been
// loaded into the output register.
// The result sits in an output register, so the next input is taken while it waits;
// a stalled receiver holds the result and blocks only the following completion.
// Reset clears the sequencer, pointers, fill count, zero run, average and registers
// to their defaults; the window RAM needs no clearing since unwritten entries are
// never read. Configuration writes on cfg_* are always taken and belong to idle time.
module angle_median_ema_filter_core #(
  parameter int WINDOW = amef_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // [17:0] raw_angle
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] filtered_angle
  output logic [1:0]                    out_tuser,  // [0] accepted, [1] filtered_valid
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amef_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [amef_pkg::CFG_DW-1:0]   cfg_data
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  amef_pkg::state_t state_r, state_nxt;

  logic [amef_pkg::GAIN_W-1:0]  gain_r;
  logic [amef_pkg::ANGLE_W-1:0] zlim_r;
  logic [amef_pkg::RUN_W-1:0]   zconf_r;

  logic [amef_pkg::ANGLE_W-1:0] angle_r, angle_c;
  logic signed [amef_pkg::RAW_W-1:0] raw;
  logic [amef_pkg::RUN_W-1:0]   zrun_r, zrun_nxt;
  logic                         accept_c, acc_r;
  logic [IW-1:0]                slot_r;
  logic [CW-1:0]                fill_r;
  logic                         avg_rdy_r;
  logic [amef_pkg::ANGLE_W-1:0] avg_r;

  logic                         in_fire, ram_we, med_start, ema_start, load_out;
  logic [IW-1:0]                ra_a, ra_b;
  logic [amef_pkg::ANGLE_W-1:0] rd_a, rd_b;
  amef_pkg::med_stat_t          med_stat;
  amef_pkg::ema_stat_t          ema_stat;

  logic                         out_valid_r, out_acc_r, out_fv_r;
  logic [amef_pkg::ANGLE_W-1:0] out_ang_r;

  assign raw = $signed(in_tdata[amef_pkg::RAW_W-1:0]);

  always_comb begin
    if (raw < 0) begin
      angle_c = '0;
    end else if (raw > $signed({2'b00, amef_pkg::ANGLE_MAX})) begin
      angle_c = amef_pkg::ANGLE_MAX;
    end else begin
      angle_c = raw[amef_pkg::ANGLE_W-1:0];
    end
  end

  always_comb begin
    zrun_nxt = zrun_r;
    accept_c = 1'b1;
    if (angle_r <= zlim_r) begin
      if (zrun_r < zconf_r) begin
        zrun_nxt = zrun_r + 8'd1;
      end
      if (zrun_nxt < zconf_r) begin
        accept_c = 1'b0;
      end
    end else begin
      zrun_nxt = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      amef_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = amef_pkg::ST_EVAL;
        end
      end
      amef_pkg::ST_EVAL: begin
        state_nxt = accept_c ? amef_pkg::ST_MED_GO : amef_pkg::ST_DONE;
      end
      amef_pkg::ST_MED_GO: begin
        state_nxt = amef_pkg::ST_MED_WAIT;
      end
      amef_pkg::ST_MED_WAIT: begin
        if (med_stat.done) begin
          state_nxt = avg_rdy_r ? amef_pkg::ST_EMA_GO : amef_pkg::ST_DONE;
        end
      end
      amef_pkg::ST_EMA_GO: begin
        state_nxt = amef_pkg::ST_EMA_WAIT;
      end
      amef_pkg::ST_EMA_WAIT: begin
        if (ema_stat.done) begin
          state_nxt = amef_pkg::ST_DONE;
        end
      end
      amef_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = amef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = amef_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == amef_pkg::ST_IDLE);
    ram_we    = (state_r == amef_pkg::ST_EVAL) && accept_c;
    med_start = (state_r == amef_pkg::ST_MED_GO);
    ema_start = (state_r == amef_pkg::ST_EMA_GO);
    load_out  = (state_r == amef_pkg::ST_DONE) && (!out_valid_r || out_tready);
  end

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amef_pkg::ST_IDLE;
      gain_r      <= amef_pkg::EMA_GAIN_RST;
      zlim_r      <= amef_pkg::ZERO_LIMIT_RST;
      zconf_r     <= amef_pkg::ZERO_CONFIRM_RST;
      zrun_r      <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      avg_rdy_r   <= 1'b0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          amef_pkg::REG_EMA_GAIN:     gain_r  <= cfg_data;
          amef_pkg::REG_ZERO_LIMIT:   zlim_r  <= cfg_data;
          amef_pkg::REG_ZERO_CONFIRM: zconf_r <= cfg_data[amef_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == amef_pkg::ST_EVAL) begin
        zrun_r <= zrun_nxt;
      end
      if (ram_we) begin
        slot_r <= (slot_r == IW'(WINDOW - 1)) ? IW'(0) : slot_r + IW'(1);
        if (fill_r < CW'(WINDOW)) begin
          fill_r <= fill_r + CW'(1);
        end
      end
      if (state_r == amef_pkg::ST_MED_WAIT && med_stat.done && !avg_rdy_r) begin
        avg_r     <= med_stat.median;
        avg_rdy_r <= 1'b1;
      end
      if (state_r == amef_pkg::ST_EMA_WAIT && ema_stat.done) begin
        avg_r <= ema_stat.value;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      angle_r <= angle_c;
    end
    if (state_r == amef_pkg::ST_EVAL) begin
      acc_r <= accept_c;
    end
    if (load_out) begin
      out_acc_r <= acc_r;
      out_ang_r <= avg_r;
      out_fv_r  <= avg_rdy_r;
    end
  end

  amef_ram #(
    .WIDTH (amef_pkg::ANGLE_W),
    .DEPTH (WINDOW),
    .AW    (IW)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .wa   (slot_r),
    .wd   (angle_r),
    .ra_a (ra_a),
    .ra_b (ra_b),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  amef_median #(
    .WINDOW (WINDOW),
    .IW     (IW),
    .CW     (CW)
  ) u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .start (med_start),
    .n     (fill_r),
    .ra_a  (ra_a),
    .ra_b  (ra_b),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .stat  (med_stat)
  );

  amef_ema u_ema (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ema_start),
    .median (med_stat.median),
    .avg    (avg_r),
    .gain   (gain_r),
    .stat   (ema_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ang_r;
  assign out_tuser  = {out_fv_r, out_acc_r};

endmodule

// ----- src/amef_ram.sv -----
// Generic single-write, dual-read synchronous RAM with registered read data.
module amef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra_a,
  input  logic [AW-1:0]    ra_b,
  output logic [WIDTH-1:0] rd_a,
  output logic [WIDTH-1:0] rd_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

// ----- src/amef_median.sv -----
// Rank-counting median engine: scans all entry pairs through the window RAM read ports.
module amef_median #(
  parameter int WINDOW = amef_pkg::WINDOW_DEFAULT,
  parameter int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  parameter int CW     = $clog2(WINDOW + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [CW-1:0]                n,
  output logic [IW-1:0]                ra_a,
  output logic [IW-1:0]                ra_b,
  input  logic [amef_pkg::ANGLE_W-1:0] rd_a,
  input  logic [amef_pkg::ANGLE_W-1:0] rd_b,
  output amef_pkg::med_stat_t          stat
);

  logic                         busy_r, busy_nxt;
  logic [CW-1:0]                i_r, i_nxt, j_r, j_nxt, n_r;
  logic                         pend_r, pfirst_r, plast_r, pdone_r;
  logic                         done_r;
  logic [CW-1:0]                lt_r, le_r, lt_sum, le_sum;
  logic [CW-1:0]                k_lo, k_hi, n_m1;
  logic [amef_pkg::ANGLE_W-1:0] lo_r, hi_r;
  logic                         j_last, i_last;
  logic [amef_pkg::ANGLE_W:0]   mid_sum;

  assign n_m1   = n_r - CW'(1);
  assign j_last = (j_r == n_m1);
  assign i_last = (i_r == n_m1);
  assign ra_a   = i_r[IW-1:0];
  assign ra_b   = j_r[IW-1:0];

  always_comb begin
    busy_nxt = busy_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      j_nxt    = '0;
    end else if (busy_r) begin
      if (j_last) begin
        j_nxt = '0;
        if (i_last) begin
          busy_nxt = 1'b0;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end
  end

  assign lt_sum = (pfirst_r ? CW'(0) : lt_r) + CW'(rd_b <  rd_a);
  assign le_sum = (pfirst_r ? CW'(0) : le_r) + CW'(rd_b <= rd_a);
  assign k_lo   = n_m1 >> 1;
  assign k_hi   = n_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      pdone_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      pend_r  <= busy_r && !start;
      pdone_r <= busy_r && !start && j_last && i_last;
      done_r  <= pend_r && pdone_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pfirst_r <= (j_r == CW'(0));
    plast_r  <= j_last;
    if (start) begin
      n_r <= n;
    end
    if (pend_r) begin
      lt_r <= lt_sum;
      le_r <= le_sum;
      if (plast_r) begin
        if (lt_sum <= k_lo && k_lo < le_sum) begin
          lo_r <= rd_a;
        end
        if (lt_sum <= k_hi && k_hi < le_sum) begin
          hi_r <= rd_a;
        end
      end
    end
  end

  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign stat.done   = done_r;
  assign stat.median = mid_sum[amef_pkg::ANGLE_W:1];

endmodule

// ----- src/amef_ema.sv -----
// Two-stage exponential average update: multiply, then round, add and clamp.
module amef_ema (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [amef_pkg::ANGLE_W-1:0] median,
  input  logic [amef_pkg::ANGLE_W-1:0] avg,
  input  logic [amef_pkg::GAIN_W-1:0]  gain,
  output amef_pkg::ema_stat_t          stat
);

  logic signed [16:0]           diff;
  logic signed [33:0]           prod_r;
  logic signed [33:0]           rnd;
  logic signed [17:0]           step;
  logic signed [18:0]           sum;
  logic [amef_pkg::ANGLE_W-1:0] res_r, res_nxt;
  logic                         v1_r, done_r;

  assign diff = $signed({1'b0, median}) - $signed({1'b0, avg});
  assign rnd  = prod_r + 34'sd32768;
  assign step = rnd[33:16];
  assign sum  = $signed({3'b000, avg}) + 19'(step);

  always_comb begin
    if (sum < 0) begin
      res_nxt = '0;
    end else if (sum > $signed({3'b000, amef_pkg::ANGLE_MAX})) begin
      res_nxt = amef_pkg::ANGLE_MAX;
    end else begin
      res_nxt = sum[amef_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= $signed({1'b0, gain}) * diff;
    end
    if (v1_r) begin
      res_r <= res_nxt;
    end
  end

  assign stat.done  = done_r;
  assign stat.value = res_r;

endmodule

// ----- src/amef_checker.sv -----
// Port-level checks for the angle median/EMA filter, bound to the top level.
module amef_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_acc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("accepted sample without a valid average");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd46080)
    else $error("filtered angle out of range");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind angle_median_ema_filter_core amef_checker u_amef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- bench/angle_median_ema_filter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the angle median/EMA filter core, with a predictor scoreboard.
module angle_median_ema_filter_core_tb;

  localparam int DEPTH = amef_pkg::WINDOW_DEFAULT;
  localparam logic [amef_pkg::CFG_AW-1:0] REG_SPARE = 8'd3;
  localparam logic [amef_pkg::CFG_AW-1:0] REG_TOP   = 8'hFF;

  typedef struct {
    logic                         accepted;
    logic [amef_pkg::ANGLE_W-1:0] angle;
    logic                         valid;
  } filter_result_t;

  class angle_filter_predictor;
    logic [amef_pkg::GAIN_W-1:0]  gain;
    logic [amef_pkg::ANGLE_W-1:0] zero_limit;
    logic [amef_pkg::RUN_W-1:0]   confirm;
    logic [amef_pkg::ANGLE_W-1:0] window [DEPTH];
    int                           write_slot;
    int                           fill_count;
    logic [amef_pkg::RUN_W-1:0]   zero_run;
    logic                         average_ready;
    logic [amef_pkg::ANGLE_W-1:0] smoothed;
    filter_result_t               expected_results [$];
    int                           failures;

    function new();
      gain          = amef_pkg::EMA_GAIN_RST;
      zero_limit    = amef_pkg::ZERO_LIMIT_RST;
      confirm       = amef_pkg::ZERO_CONFIRM_RST;
      write_slot    = 0;
      fill_count    = 0;
      zero_run      = '0;
      average_ready = 1'b0;
      smoothed      = '0;
      failures      = 0;
    endfunction

    function void write_reg(logic [amef_pkg::CFG_AW-1:0] idx,
                            logic [amef_pkg::CFG_DW-1:0] value);
      case (idx)
        amef_pkg::REG_EMA_GAIN:     gain = value;
        amef_pkg::REG_ZERO_LIMIT:   zero_limit = value;
        amef_pkg::REG_ZERO_CONFIRM: confirm = value[amef_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    // median of the filled entries; even count gives the floor of the middle mean
    function int window_median();
      int ordered [DEPTH];
      int i;
      int p;
      int v;
      for (i = 0; i < fill_count; i++) begin
        ordered[i] = int'(window[i]);
      end
      for (i = 1; i < fill_count; i++) begin
        v = ordered[i];
        p = i;
        while (p > 0 && v < ordered[p-1]) begin
          ordered[p] = ordered[p-1];
          p--;
        end
        ordered[p] = v;
      end
      if (fill_count % 2 == 0) begin
        return (ordered[fill_count/2-1] + ordered[fill_count/2]) >> 1;
      end
      return ordered[fill_count/2];
    endfunction

    function void take_angle(logic signed [amef_pkg::RAW_W-1:0] raw);
      int             sval;
      int             angle;
      int             med;
      longint         d;
      longint         ns;
      bit             accept;
      filter_result_t r;
      sval   = int'(raw);
      accept = 1'b1;
      if (sval < 0) angle = 0;
      else if (sval > int'(amef_pkg::ANGLE_MAX)) angle = int'(amef_pkg::ANGLE_MAX);
      else angle = sval;

      if (angle <= int'(zero_limit)) begin
        if (zero_run < confirm) zero_run++;
        if (zero_run < confirm) accept = 1'b0;
      end else begin
        zero_run = '0;
      end

      if (accept) begin
        window[write_slot] = angle[amef_pkg::ANGLE_W-1:0];
        write_slot = (write_slot + 1) % DEPTH;
        if (fill_count < DEPTH) fill_count++;
        med = window_median();
        if (!average_ready) begin
          smoothed      = med[amef_pkg::ANGLE_W-1:0];
          average_ready = 1'b1;
        end else begin
          d  = longint'(med) - longint'(smoothed);
          ns = longint'(smoothed) + ((longint'(gain) * d + 64'sd32768) >>> 16);
          if (ns < 0) ns = 0;
          if (ns > longint'(amef_pkg::ANGLE_MAX)) ns = longint'(amef_pkg::ANGLE_MAX);
          smoothed = ns[amef_pkg::ANGLE_W-1:0];
        end
      end
      r.accepted = accept;
      r.angle    = smoothed;
      r.valid    = average_ready;
      expected_results.push_back(r);
    endfunction

    function void compare_result(logic accepted, logic [amef_pkg::ANGLE_W-1:0] angle,
                                 logic valid);
      filter_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: accepted %0d filtered_angle %0d", accepted,
               angle);
        failures++;
        return;
      end
      e = expected_results.pop_front();
      if (accepted !== e.accepted) begin
        $error("accepted: expected %0d, actual %0d", e.accepted, accepted);
        failures++;
      end
      if (angle !== e.angle) begin
        $error("filtered_angle: expected %0d, actual %0d", e.angle, angle);
        failures++;
      end
      if (valid !== e.valid) begin
        $error("filtered_valid: expected %0d, actual %0d", e.valid, valid);
        failures++;
      end
    endfunction
  endclass

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [23:0]                 in_tdata   = '0;   // [17:0] raw_angle
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [15:0]                 out_tdata;         // [15:0] filtered_angle
  logic [1:0]                  out_tuser;         // [0] accepted, [1] filtered_valid
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [amef_pkg::CFG_AW-1:0] cfg_addr   = '0;
  logic [amef_pkg::CFG_DW-1:0] cfg_data   = '0;

  bit quiet = 1'b0;
  angle_filter_predictor pred = new();

  angle_median_ema_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pred.compare_result(out_tuser[0], out_tdata, out_tuser[1]);
    end
  end

  task automatic send_angle(input logic signed [amef_pkg::RAW_W-1:0] raw);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, raw};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    pred.take_angle(raw);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pred.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // raises the write channel and holds it; the caller lowers it after its last write
  task automatic cfg_beat(input logic [amef_pkg::CFG_AW-1:0] idx,
                          input logic [amef_pkg::CFG_DW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    pred.write_reg(idx, value);
  endtask

  task automatic program_filter(input logic [amef_pkg::CFG_DW-1:0] gain,
                                input logic [amef_pkg::CFG_DW-1:0] lim,
                                input logic [amef_pkg::CFG_DW-1:0] conf, input bit spare);
    drain_results();
    cfg_beat(amef_pkg::REG_EMA_GAIN, gain);
    cfg_beat(amef_pkg::REG_ZERO_LIMIT, lim);
    cfg_beat(amef_pkg::REG_ZERO_CONFIRM, conf);
    if (spare) begin
      cfg_beat(REG_SPARE, amef_pkg::CFG_DW'($urandom));
      cfg_beat(REG_TOP, amef_pkg::CFG_DW'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [amef_pkg::RAW_W-1:0] pick_angle(bit zeroish);
    int k;
    int top;
    if (zeroish) begin
      top = (pred.zero_limit > amef_pkg::ANGLE_MAX) ? int'(amef_pkg::ANGLE_MAX) :
                                                      int'(pred.zero_limit);
      if ($urandom_range(0, 1) == 1) begin
        return amef_pkg::RAW_W'(-int'($urandom_range(1, 131072)));
      end
      return amef_pkg::RAW_W'($urandom_range(0, top));
    end
    k = $urandom_range(0, 99);
    if (k < 10) return amef_pkg::RAW_W'($urandom);
    if (k < 20) return amef_pkg::RAW_W'($urandom_range(46081, 131071));
    return amef_pkg::RAW_W'($urandom_range(0, 46080));
  endfunction

  // receiver: random stall before each result, none while quiet
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin
    #4_000_000;
    $display("angle_median_ema_filter_core verification failed");
    $finish;
  end

  initial begin
    int directed_angles [16];
    int phase_items;
    int sent;
    int run;
    bit burst;
    directed_angles = '{0, -1, -131072, 131071, 46080, 46081, 128, 129,
                        1, 2, 3, 23040, 65536, -65536, 20000, 46079};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_angles[i]) send_angle(amef_pkg::RAW_W'(directed_angles[i]));

    for (int phase = 0; phase < 8; phase++) begin
      phase_items = 120;
      case (phase)
        0: program_filter(16'hFFFF, 16'd0, 16'd1, 1'b0);
        1: begin
          program_filter(16'd0, amef_pkg::ANGLE_MAX, 16'd255, 1'b0);
          phase_items = 300;
        end
        2: program_filter(16'd1, 16'hFFFF, 16'd0, 1'b0);
        3: program_filter(amef_pkg::CFG_DW'($urandom), 16'd2000, 16'h1F02, 1'b1);
        4: program_filter(amef_pkg::CFG_DW'(amef_pkg::EMA_GAIN_RST),
                          amef_pkg::CFG_DW'(amef_pkg::ZERO_LIMIT_RST),
                          amef_pkg::CFG_DW'(amef_pkg::ZERO_CONFIRM_RST), 1'b1);
        default: program_filter(amef_pkg::CFG_DW'($urandom),
                                amef_pkg::CFG_DW'($urandom_range(0, 3000)),
                                amef_pkg::CFG_DW'($urandom_range(0, 6)), 1'b0);
      endcase
      sent = 0;
      while (sent < phase_items) begin
        if (sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        burst = ($urandom_range(0, 9) == 0);
        run   = burst ? $urandom_range(1, int'(pred.confirm) + 3) : 1;
        for (int j = 0; j < run; j++) send_angle(pick_angle(burst));
        sent += run;
      end
      quiet = 1'b0;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (pred.failures == 0) begin
      $display("angle_median_ema_filter_core verification clean");
    end else begin
      $display("angle_median_ema_filter_core verification failed");
    end
    $finish;
  end

endmodule
